FILE: src/lift_actuator_sequencer_defines.svh
// Assertion macros for the lift actuator sequencer.
// LAS_ASSERT checks a property while out of reset; LAS_ASSERT_ALWAYS
// also checks it during reset.
`ifndef LIFT_ACTUATOR_SEQUENCER_DEFINES_SVH
`define LIFT_ACTUATOR_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
`define LAS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
`define LAS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define LAS_ASSERT(label, prop, msg)
`define LAS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: src/las_pkg.sv
`default_nettype none

package las_pkg;

    localparam int HEIGHT_W = 16;
    localparam int TICKS_W  = 16;
    localparam int TOL_W    = 10;
    localparam int DUTY_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DUTY_W-1:0] FULL_DUTY = 10'd1023;

    localparam logic [TICKS_W-1:0] CENTER_RUN_RESET = 16'd1300;
    localparam logic [TOL_W-1:0]   TOLERANCE_RESET  = 10'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_MODE     = 2'd0,
        CFG_CENTER_RUN_TICKS = 2'd1,
        CFG_ARRIVE_TOLERANCE = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        CMD_NONE = 3'd0,
        CMD_UP   = 3'd1,
        CMD_DOWN = 3'd2,
        CMD_STOP = 3'd3,
        CMD_GOTO = 3'd4,
        CMD_CAL  = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_TOP      = 3'd1,
        EV_BOTTOM   = 3'd2,
        EV_REACHED  = 3'd3,
        EV_CAL_DONE = 3'd4
    } t_event;

    typedef enum logic [3:0] {
        M_STOP   = 4'd0,
        M_UP     = 4'd1,
        M_DOWN   = 4'd2,
        M_GUP    = 4'd3,
        M_GDOWN  = 4'd4,
        M_CDOWN  = 4'd5,
        M_CUP    = 4'd6,
        M_CGUP   = 4'd7,
        M_CGDOWN = 4'd8,
        M_CTIMED = 4'd9
    } t_mode;

    typedef struct packed {
        logic                initial_mode;
        logic [TICKS_W-1:0]  center_run_ticks;
        logic [TOL_W-1:0]    arrive_tolerance;
    } t_cfg;

    typedef struct packed {
        logic [2:0]          command;
        logic [HEIGHT_W-1:0] height_now;
        logic [HEIGHT_W-1:0] target_height;
        logic                top_hit;
        logic                bottom_hit;
    } t_item;

    typedef struct packed {
        t_mode               mode;
        logic [HEIGHT_W-1:0] goal;
        logic [HEIGHT_W-1:0] bottom_mark;
        logic [HEIGHT_W-1:0] top_mark;
        logic [TICKS_W-1:0]  run_timer;
    } t_state;

    typedef struct packed {
        logic [DUTY_W-1:0]   duty;
        logic                going_down;
        logic                awake;
        logic                busy_res;
        logic                calibrating_now;
        t_event              event_res;
        logic [HEIGHT_W-1:0] low_end;
        logic [HEIGHT_W-1:0] high_end;
    } t_result;

endpackage

`default_nettype wire

FILE: src/las_cfg.sv
`default_nettype none

module las_cfg import las_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_mode     <= 1'b0;
            r_cfg.center_run_ticks <= CENTER_RUN_RESET;
            r_cfg.arrive_tolerance <= TOLERANCE_RESET;
        end else if (i_cfg_wen) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_INITIAL_MODE:     r_cfg.initial_mode     <= i_cfg_data[0];
                CFG_CENTER_RUN_TICKS: r_cfg.center_run_ticks <= i_cfg_data[TICKS_W-1:0];
                CFG_ARRIVE_TOLERANCE: r_cfg.arrive_tolerance <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: src/las_step.sv
`default_nettype none

module las_step import las_pkg::*; (
    input  wire t_state  i_state,
    input  wire t_item   i_item,
    input  wire t_cfg    i_cfg,
    output t_state  o_state,
    output t_result o_result
);

    t_state              s;
    t_event              ev;
    logic                do_cal;
    logic                do_goto;
    logic                goto_cal;
    logic                do_eval;
    logic [HEIGHT_W-1:0] goto_target;
    logic [HEIGHT_W:0]   mark_sum;
    logic [HEIGHT_W-1:0] diff;
    logic                is_cal;
    logic                is_up;
    logic                running;
    logic                down;
    logic [HEIGHT_W-1:0] h;
    logic                top;
    logic                bot;

    assign h   = i_item.height_now;
    assign top = i_item.top_hit;
    assign bot = i_item.bottom_hit;

    always_comb begin
        s           = i_state;
        ev          = EV_NONE;
        do_cal      = 1'b0;
        do_goto     = 1'b0;
        goto_cal    = 1'b0;
        do_eval     = 1'b0;
        goto_target = i_item.target_height;
        mark_sum    = '0;
        diff        = '0;
        is_cal      = 1'b0;
        is_up       = 1'b0;

        if (s.mode > M_CTIMED) begin
            s.mode = M_STOP;
        end

        case (s.mode)
            M_STOP, M_UP, M_DOWN: begin
                if (s.mode == M_UP && top) begin
                    s.mode = M_STOP;
                    ev     = EV_TOP;
                end
                if (s.mode == M_DOWN && bot) begin
                    s.mode = M_STOP;
                    ev     = EV_BOTTOM;
                end
                case (i_item.command)
                    CMD_UP:   s.mode = top ? M_STOP : M_UP;
                    CMD_DOWN: s.mode = bot ? M_STOP : M_DOWN;
                    CMD_STOP: s.mode = M_STOP;
                    CMD_GOTO: do_goto = 1'b1;
                    CMD_CAL: begin
                        s.mode = M_CDOWN;
                        do_cal = 1'b1;
                    end
                    default: ;
                endcase
            end
            M_CDOWN, M_CUP: do_cal = 1'b1;
            M_CTIMED: begin
                if (s.run_timer != '0) begin
                    s.run_timer = s.run_timer - 1'b1;
                end
                if (s.run_timer == '0) begin
                    s.mode = M_STOP;
                    ev     = EV_CAL_DONE;
                end
            end
            M_GUP, M_GDOWN, M_CGUP, M_CGDOWN: do_eval = 1'b1;
            default: s.mode = M_STOP;
        endcase

        // calibration phases chain within the tick when the switch is already active
        if (do_cal) begin
            if (s.mode == M_CDOWN && bot) begin
                s.bottom_mark = h;
                s.mode        = M_CUP;
            end
            if (s.mode == M_CUP && top) begin
                s.top_mark = h;
                if (i_cfg.initial_mode) begin
                    s.run_timer = i_cfg.center_run_ticks;
                    if (i_cfg.center_run_ticks == '0) begin
                        s.mode = M_STOP;
                        ev     = EV_CAL_DONE;
                    end else begin
                        s.mode = M_CTIMED;
                    end
                end else begin
                    mark_sum    = {1'b0, s.bottom_mark} + {1'b0, s.top_mark};
                    goto_target = mark_sum[HEIGHT_W:1];
                    do_goto     = 1'b1;
                    goto_cal    = 1'b1;
                end
            end
        end

        if (do_goto) begin
            s.goal = goto_target;
            if (goto_target > h) begin
                s.mode = goto_cal ? M_CGUP : M_GUP;
            end else begin
                s.mode = goto_cal ? M_CGDOWN : M_GDOWN;
            end
            do_eval = 1'b1;
        end

        if (do_eval) begin
            is_cal = (s.mode == M_CGUP) || (s.mode == M_CGDOWN);
            is_up  = (s.mode == M_GUP) || (s.mode == M_CGUP);
            diff   = (h > s.goal) ? (h - s.goal) : (s.goal - h);
            if (is_up && top) begin
                s.mode = M_STOP;
                ev     = is_cal ? EV_CAL_DONE : EV_TOP;
            end else if (!is_up && bot) begin
                s.mode = M_STOP;
                ev     = is_cal ? EV_CAL_DONE : EV_BOTTOM;
            end else if (diff < {{(HEIGHT_W-TOL_W){1'b0}}, i_cfg.arrive_tolerance}) begin
                s.mode = M_STOP;
                ev     = is_cal ? EV_CAL_DONE : EV_REACHED;
            end
        end
    end

    assign running = (s.mode != M_STOP);
    assign down    = (s.mode == M_DOWN) || (s.mode == M_GDOWN) || (s.mode == M_CDOWN) ||
                     (s.mode == M_CGDOWN) || (s.mode == M_CTIMED);

    assign o_state                  = s;
    assign o_result.duty            = running ? FULL_DUTY : '0;
    assign o_result.going_down      = down;
    assign o_result.awake           = running;
    assign o_result.busy_res        = (s.mode >= M_GUP);
    assign o_result.calibrating_now = (s.mode >= M_CDOWN);
    assign o_result.event_res       = ev;
    assign o_result.low_end         = s.bottom_mark;
    assign o_result.high_end        = s.top_mark;

endmodule

`default_nettype wire

FILE: src/lift_actuator_sequencer.sv
// Lift actuator sequencer: one poll tick in, one motor/status result out.
// A tick passes the input register, then the result register. One tick per
// cycle unless the output stalls; the input register and the result register
// each advance whenever the stage after them is empty or being drained.
// Reset (synchronous, active low): motor stopped, marks, goal and timer zero,
// registers back to their reset values, both stages empty.
`default_nettype none
`include "lift_actuator_sequencer_defines.svh"

module lift_actuator_sequencer import las_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,

    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [2:0]            i_command,
    input  wire logic [HEIGHT_W-1:0]   i_height_now,
    input  wire logic [HEIGHT_W-1:0]   i_target_height,
    input  wire logic                  i_top_hit,
    input  wire logic                  i_bottom_hit,

    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [DUTY_W-1:0]          o_duty,
    output logic                       o_going_down,
    output logic                       o_awake,
    output logic                       o_busy_res,
    output logic                       o_calibrating_now,
    output logic [2:0]                 o_event_res,
    output logic [HEIGHT_W-1:0]        o_low_end,
    output logic [HEIGHT_W-1:0]        o_high_end
);

    t_cfg    w_cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_state  r_state;
    t_state  n_state;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    w_adv;
    logic    w_in_xfer;

    las_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    las_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign w_adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_adv;
    assign w_in_xfer = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in.command       <= i_command;
            r_in.height_now    <= i_height_now;
            r_in.target_height <= i_target_height;
            r_in.top_hit       <= i_top_hit;
            r_in.bottom_hit    <= i_bottom_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode        <= M_STOP;
            r_state.goal        <= '0;
            r_state.bottom_mark <= '0;
            r_state.top_mark    <= '0;
            r_state.run_timer   <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_duty            = r_out.duty;
    assign o_going_down      = r_out.going_down;
    assign o_awake           = r_out.awake;
    assign o_busy_res        = r_out.busy_res;
    assign o_calibrating_now = r_out.calibrating_now;
    assign o_event_res       = r_out.event_res;
    assign o_low_end         = r_out.low_end;
    assign o_high_end        = r_out.high_end;

    `LAS_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "result valid after reset")
    `LAS_ASSERT(a_awake_duty, o_valid |-> (o_awake == (o_duty != '0)), "awake and duty disagree")
    `LAS_ASSERT(a_cal_busy, o_valid && o_calibrating_now |-> o_busy_res, "calibrating but not busy")
    `LAS_ASSERT(a_done_stopped, o_valid && (o_event_res == EV_REACHED || o_event_res == EV_CAL_DONE) |-> !o_awake && !o_busy_res, "motor running after sequence end")
    `LAS_ASSERT(a_state_hold, r_out_valid && !i_ready |=> $stable(r_state), "state moved while result stalled")

endmodule

`default_nettype wire
